/* hdl/kfc_pkg.sv */
package kfc_pkg;

    localparam int KEY_W = 31;
    localparam int PROD_W = 31;
    localparam int QTY_W = 16;
    localparam int AMT_W = 32;

    typedef struct packed {
        logic [KEY_W-1:0]  order_id;
        logic [PROD_W-1:0] product_id;
        logic [QTY_W-1:0]  quantity;
        logic [AMT_W-1:0]  amount_cents;
    } kfc_rec_t;

    localparam int REC_W = $bits(kfc_rec_t);

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_FIND   = 2'd2,
        OP_CANCEL = 2'd3
    } kfc_op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } kfc_status_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DEQ   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_SHIFT = 4'b1000
    } kfc_state_t;

endpackage

/* hdl/kfc_ram.sv */
module kfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/kfc_slot.sv */
module kfc_slot #(
    parameter int DEPTH = 16
) (
    input  logic [$clog2(DEPTH)-1:0]   base,
    input  logic [$clog2(DEPTH+1)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0]   slot
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    // The sum stays below twice the depth, so one subtract brings it into range.
    always_comb
    begin
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= DEPTH_S)
        begin
            wrapped = sum - DEPTH_S;
        end
        else
        begin
            wrapped = sum;
        end
        slot = wrapped[PTR_W-1:0];
    end

endmodule

/* hdl/keyed_fifo_with_cancel_unit.sv */
// Channel  | Signals                                              | Transfer
// ---------+------------------------------------------------------+---------------------------
// command  | start, busy, op, order_id, product_id, quantity,     | start high while busy low
//          | amount_cents                                         |
// result   | done, status, out_order_id, out_product_id,          | done high for one cycle
//          | out_quantity, out_amount_cents, occupancy            |
//
// Enqueue, and any operation that fails on an empty or full queue, gives its result in the
// cycle after the transfer and never raises busy. Dequeue returns the head record from ST_DEQ.
// Find scans the records from the front until the key matches or they run out; cancel scans
// likewise, then moves each record behind the match one place forward, one entry per cycle
// through the single read port of the record memory for both the key scan and the compaction.
// Reset clears the pointers and count at once; no clearing pass. Results cannot be stalled.
module keyed_fifo_with_cancel_unit
    import kfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [KEY_W-1:0]               order_id,
    input  logic [PROD_W-1:0]              product_id,
    input  logic [QTY_W-1:0]               quantity,
    input  logic [AMT_W-1:0]               amount_cents,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [KEY_W-1:0]               out_order_id,
    output logic [PROD_W-1:0]              out_product_id,
    output logic [QTY_W-1:0]               out_quantity,
    output logic [AMT_W-1:0]               out_amount_cents,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    kfc_state_t  state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pidx_reg, pidx_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    kfc_op_t          op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    kfc_status_t      status_reg, status_next;
    kfc_rec_t         rec_out_reg, rec_out_next;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    kfc_rec_t         wr_rec;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [REC_W-1:0] rd_data;
    kfc_rec_t         rd_rec;
    logic [PTR_W-1:0] tail_slot;
    logic [PTR_W-1:0] scan_slot;
    logic [PTR_W-1:0] move_slot;
    kfc_rec_t         in_rec;
    logic             hit;

    kfc_slot #(.DEPTH(QUEUE_DEPTH)) u_tail_slot (
        .base   (head_reg),
        .offset (count_reg),
        .slot   (tail_slot)
    );

    kfc_slot #(.DEPTH(QUEUE_DEPTH)) u_scan_slot (
        .base   (head_reg),
        .offset (idx_reg),
        .slot   (scan_slot)
    );

    kfc_slot #(.DEPTH(QUEUE_DEPTH)) u_move_slot (
        .base   (head_reg),
        .offset (pidx_reg),
        .slot   (move_slot)
    );

    kfc_ram #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_rec = kfc_rec_t'(rd_data);
    assign in_rec = '{order_id: order_id, product_id: product_id,
                      quantity: quantity, amount_cents: amount_cents};
    assign hit = pend_reg && (rd_rec.order_id == key_reg);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        pend_next    = pend_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        rec_out_next = rec_out_reg;
        wr_en        = 1'b0;
        wr_addr      = tail_slot;
        wr_rec       = in_rec;
        rd_en        = 1'b0;
        rd_addr      = scan_slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = kfc_op_t'(op);
                    key_next = order_id;
                    case (kfc_op_t'(op))
                        OP_ENQ:
                        begin
                            done_next    = 1'b1;
                            rec_out_next = '0;
                            if (count_reg == DEPTH_CNT)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                status_next = STS_OK;
                                wr_en       = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next    = 1'b1;
                                status_next  = STS_EMPTY;
                                rec_out_next = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = ST_DEQ;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next    = 1'b1;
                                status_next  = STS_NOT_FOUND;
                                rec_out_next = '0;
                            end
                            else
                            begin
                                idx_next   = '0;
                                pend_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_DEQ:
            begin
                done_next    = 1'b1;
                status_next  = STS_OK;
                rec_out_next = rd_rec;
                head_next    = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
                count_next   = count_reg - CNT_W'(1);
                state_next   = ST_IDLE;
            end

            ST_SCAN:
            begin
                // One key read is issued per cycle; its compare follows in the next cycle.
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (op_reg == OP_FIND)
                    begin
                        done_next    = 1'b1;
                        status_next  = STS_OK;
                        rec_out_next = rd_rec;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = pidx_reg + CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (pend_reg && (pidx_reg == count_reg - CNT_W'(1)))
                begin
                    pend_next    = 1'b0;
                    done_next    = 1'b1;
                    status_next  = STS_NOT_FOUND;
                    rec_out_next = '0;
                    state_next   = ST_IDLE;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_SHIFT:
            begin
                // Each record behind the removed one is read and written one place forward.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = move_slot;
                    wr_rec  = rd_rec;
                end
                if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg - CNT_W'(1);
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next    = 1'b0;
                    done_next    = 1'b1;
                    status_next  = STS_OK;
                    rec_out_next = '0;
                    count_next   = count_reg - CNT_W'(1);
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pidx_reg    <= pidx_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        rec_out_reg <= rec_out_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign out_order_id     = rec_out_reg.order_id;
    assign out_product_id   = rec_out_reg.product_id;
    assign out_quantity     = rec_out_reg.quantity;
    assign out_amount_cents = rec_out_reg.amount_cents;
    assign occupancy        = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond queue depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_PTR)
        else $error("head pointer out of range");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_ENQ) && (count_reg != DEPTH_CNT))
        |=> (done_reg && (count_reg == $past(count_reg) + CNT_W'(1))))
        else $error("enqueue did not store a record");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STS_FULL)) |-> (count_reg == DEPTH_CNT))
        else $error("full reported on a queue with room");

    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (state_reg == ST_SCAN)) |-> (pidx_reg < count_reg))
        else $error("scan compare beyond stored records");

endmodule
